// File: design/sha1_message_digest_defines.svh
// Assertion macros for the file that checks its own logic.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, checked at every rising edge of clk outside reset.
`define SHA1_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge of clk outside reset.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sha1_md_pkg.sv
package sha1_md_pkg;

	// Block geometry.
	localparam int BLOCK_BITS  = 512;
	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 5;

	// Fill level at which the 64-bit length field begins.
	localparam logic [5:0] LEN_START = 6'd56;
	// Fill level of the last byte slot in a block.
	localparam logic [5:0] FILL_LAST = 6'd63;

	// First padding byte.
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Last round index of the compression function.
	localparam logic [6:0] LAST_ROUND = 7'd79;

	// Initial chaining values.
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	// Round constants.
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// Five chaining words, word 0 at index 0.
	typedef logic [CHAIN_WORDS-1:0][31:0] chain_t;

	// Commands from the sequencer to the compression core.
	typedef struct packed {
		logic start;
		logic init;
	} core_ctrl_t;

	// Status from the compression core to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	// Boolean function of one round.
	function automatic logic [31:0] sha1_f(input logic [6:0] round,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (round < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (round < 7'd40) begin
			f = b ^ c ^ d;
		end else if (round < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	// Additive constant of one round.
	function automatic logic [31:0] sha1_k(input logic [6:0] round);
		logic [31:0] k;
		if (round < 7'd20) begin
			k = K0;
		end else if (round < 7'd40) begin
			k = K1;
		end else if (round < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage

// File: design/sha1_md_core.sv
module sha1_md_core
	import sha1_md_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  core_ctrl_t            ctrl,
	input  logic [BLOCK_BITS-1:0] block,
	output chain_t                chain,
	output core_stat_t            stat
);

	// Sliding window of the message schedule, current word at index 0.
	logic [BLOCK_WORDS-1:0][31:0] w_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	chain_t      h_q;
	logic [6:0]  round_q;
	logic        busy_q;
	logic        fin_q;

	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] w_mix;
	logic [31:0] w_new;

	// One round of the compression function and the next schedule word.
	always_comb begin
		f_val = sha1_f(round_q, b_q, c_q, d_q);
		k_val = sha1_k(round_q);
		t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];
		w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_mix[30:0], w_mix[31]};
	end

	// Round counter and chaining state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			round_q <= '0;
			h_q     <= {IV4, IV3, IV2, IV1, IV0};
		end else begin
			fin_q <= 1'b0;
			if (ctrl.start && !busy_q) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				if (round_q == LAST_ROUND) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				round_q <= round_q + 7'd1;
			end
			// Fold the working variables into the chain after the last round.
			if (fin_q) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end else if (ctrl.init && !busy_q) begin
				h_q <= {IV4, IV3, IV2, IV1, IV0};
			end
		end
	end

	// Working variables and schedule window.
	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				w_q[i] <= block[BLOCK_BITS-1-32*i -: 32];
			end
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (busy_q) begin
			for (int i = 0; i < BLOCK_WORDS-1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_WORDS-1] <= w_new;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t_val;
		end
	end

	assign chain     = h_q;
	assign stat.busy = busy_q;
	assign stat.done = fin_q;

endmodule

// File: design/sha1_message_digest.sv
// SHA-1 message digest over a byte stream.
// Input channel s_axis: one transaction per item. tdata holds one message byte,
// tuser says whether that byte is present, tlast marks the final item of a message.
// Output channel m_axis: five transactions per message, the 32-bit digest words
// in order from word 0, with tlast on the fifth.
// An item is taken whenever the sequencer is idle. The 64th byte of a block starts
// the round unit, which runs one round per cycle: the block is not ready during
// the load, the rounds and the chain update. An item marked last is followed by
// padding, one byte per cycle into the block shift register while no block is
// being compressed, and one or two compressions before the first digest word shows.
// The digest sits in its own output register, so the next message is taken
// while it drains; a new digest waits in the chaining state, with the input
// not ready, only if the old one is still held.
// A stalled receiver holds the current word and tlast until the transaction.
// Reset clears the chaining state to the initial hash values, the fill count,
// the bit count and the output word count; no item is lost or repeated.
`include "sha1_message_digest_defines.svh"

module sha1_message_digest
	import sha1_md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic        m_axis_tlast
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_COMP   = 3'd1;
	localparam logic [2:0] ST_PAD80  = 3'd2;
	localparam logic [2:0] ST_PADZ   = 3'd3;
	localparam logic [2:0] ST_LEN    = 3'd4;
	localparam logic [2:0] ST_DIGEST = 3'd5;

	logic [2:0]            state_q;
	logic [2:0]            ret_q;
	logic                  go_q;
	logic [5:0]            fill_q;
	logic [63:0]           total_q;
	logic [63:0]           len_q;
	logic [BLOCK_BITS-1:0] buf_q;
	chain_t                out_q;
	logic [2:0]            cnt_q;

	logic       in_acc;
	logic       out_acc;
	logic       shift_en;
	logic [7:0] shift_byte;
	logic       block_full;

	core_ctrl_t core_ctrl;
	core_stat_t core_stat;
	chain_t     chain;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign m_axis_tdata  = out_q[0];
	assign m_axis_tlast  = (cnt_q == 3'd1);
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	// Byte that enters the block register this cycle.
	always_comb begin
		shift_en   = 1'b0;
		shift_byte = 8'h00;
		case (state_q)
			ST_IDLE: begin
				shift_en   = in_acc && s_axis_tuser;
				shift_byte = s_axis_tdata;
			end
			ST_PAD80: begin
				shift_en   = 1'b1;
				shift_byte = PAD_BYTE;
			end
			ST_PADZ: begin
				shift_en   = (fill_q != LEN_START);
				shift_byte = 8'h00;
			end
			ST_LEN: begin
				shift_en   = 1'b1;
				shift_byte = len_q[63:56];
			end
			default: begin
				shift_en   = 1'b0;
				shift_byte = 8'h00;
			end
		endcase
		block_full = shift_en && (fill_q == FILL_LAST);
	end

	assign core_ctrl.start = go_q;
	assign core_ctrl.init  = (state_q == ST_DIGEST) && (cnt_q == 3'd0);

	// Block shift register: the first byte of a block ends up in the top bits.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			buf_q <= {buf_q[BLOCK_BITS-9:0], shift_byte};
		end
		if (state_q == ST_PAD80) begin
			len_q <= total_q + {55'd0, fill_q, 3'd0};
		end else if (state_q == ST_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Sequencer over message bytes, padding and compressions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			go_q    <= 1'b0;
			fill_q  <= '0;
			total_q <= '0;
		end else begin
			go_q <= 1'b0;
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (block_full) begin
							go_q    <= 1'b1;
							state_q <= ST_COMP;
							total_q <= total_q + 64'(BLOCK_BITS);
							ret_q   <= s_axis_tlast ? ST_PAD80 : ST_IDLE;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD80;
						end
					end
				end
				ST_COMP: begin
					if (core_stat.done) begin
						state_q <= ret_q;
					end
				end
				ST_PAD80: begin
					if (block_full) begin
						go_q    <= 1'b1;
						state_q <= ST_COMP;
						ret_q   <= ST_PADZ;
					end else begin
						state_q <= ST_PADZ;
					end
				end
				ST_PADZ: begin
					if (fill_q == LEN_START) begin
						state_q <= ST_LEN;
					end else if (block_full) begin
						go_q    <= 1'b1;
						state_q <= ST_COMP;
						ret_q   <= ST_PADZ;
					end
				end
				ST_LEN: begin
					if (block_full) begin
						go_q    <= 1'b1;
						state_q <= ST_COMP;
						ret_q   <= ST_DIGEST;
					end
				end
				ST_DIGEST: begin
					if (cnt_q == 3'd0) begin
						total_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: five digest words, drained one per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (core_ctrl.init) begin
			cnt_q <= 3'(CHAIN_WORDS);
		end else if (out_acc) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ctrl.init) begin
			out_q <= chain;
		end else if (out_acc) begin
			for (int i = 0; i < CHAIN_WORDS-1; i++) begin
				out_q[i] <= out_q[i+1];
			end
		end
	end

	sha1_md_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (core_ctrl),
		.block  (buf_q),
		.chain  (chain),
		.stat   (core_stat)
	);

	// The round unit runs only while the sequencer waits for it.
	`SHA1_ASSERT_SAME(a_busy_in_comp, core_stat.busy || core_stat.done, state_q == ST_COMP,
		"round unit active outside a compression")
	// A start is only issued to an idle round unit, which then becomes busy.
	`SHA1_ASSERT_NEXT(a_start_busy, go_q, core_stat.busy && (state_q == ST_COMP),
		"compression start not taken by the round unit")
	// Loading the digest fills the output register with all five words.
	`SHA1_ASSERT_NEXT(a_digest_load, (state_q == ST_DIGEST) && (cnt_q == 3'd0),
		(cnt_q == 3'(CHAIN_WORDS)) && (state_q == ST_IDLE), "digest load failed")
	// The length field always begins at its fixed place in the block.
	`SHA1_ASSERT_SAME(a_len_place, (state_q == ST_LEN) && !$past(state_q == ST_LEN),
		fill_q == LEN_START, "length field misplaced")

endmodule
